[rtl/cvt_pkg.sv]
// Shared constants and types for the camera view transform unit.
package cvt_pkg;

   localparam int COORD_W  = 32;
   localparam int ANGLE_W  = 16;
   localparam int ZOOM_W   = 16;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 3;

   // Request and response buses.
   localparam int REQ_DATA_W = 2 * COORD_W;
   localparam int RSP_DATA_W = 2 * COORD_W;

   // Sine generator: 24-bit turn fraction, result in Q24 with a sign bit.
   localparam int PHASE_W  = 24;
   localparam int PHASE_SHIFT = PHASE_W - ANGLE_W;
   localparam int SIN_W    = 26;
   localparam int SIN_FRAC = 24;
   localparam logic [PHASE_W-1:0] QUARTER_TURN = 24'h400000;
   localparam logic [30:0] POLY_A = 31'd1686629713;
   localparam logic [29:0] POLY_B = 30'd688904866;
   localparam logic [26:0] POLY_C = 27'd76016977;

   // Zoom limits in Q4.12.
   localparam logic [ZOOM_W-1:0] ZOOM_MIN   = 16'd410;
   localparam logic [ZOOM_W-1:0] ZOOM_MAX   = 16'd40960;
   localparam logic [ZOOM_W-1:0] ZOOM_RESET = 16'd4096;

   // Long division of the screen offset by zoom.
   localparam int DIV_W = 48;
   localparam int DIV_BITS_PER_STAGE = 4;
   localparam int DIV_STAGES = DIV_W / DIV_BITS_PER_STAGE;
   localparam int QUO_W = 37;

   // Datapath widths.
   localparam int CEN_W   = 34;
   localparam int DIFF_W  = 35;
   localparam int DELTA_W = COORD_W + 1;
   localparam int OPER_W  = 38;
   localparam int SPLIT_W = 19;
   localparam int PART_W  = 46;
   localparam int PROD_W  = 64;
   localparam int ROT_W   = PROD_W - SIN_FRAC;
   localparam int SCALE_W = 36;
   localparam int SUM_W   = 56;
   localparam int CEN_SHIFT   = 11;
   localparam int SCALE_SHIFT = 12;

   localparam logic MODE_S2W = 1'b0;
   localparam logic MODE_W2S = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VIEW_LEFT   = 3'd0,
      CSR_VIEW_TOP    = 3'd1,
      CSR_VIEW_WIDTH  = 3'd2,
      CSR_VIEW_HEIGHT = 3'd3,
      CSR_CAM_X       = 3'd4,
      CSR_CAM_Y       = 3'd5,
      CSR_ZOOM        = 3'd6,
      CSR_ANGLE       = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic vld;
      logic mode;
   } stage_ctl_type;

   // What travels beside the divider.
   typedef struct packed {
      logic                      vld;
      logic                      mode;
      logic                      neg_x;
      logic                      neg_y;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
   } side_type;

   typedef struct packed {
      logic signed [PART_W-1:0] hi;
      logic signed [PART_W-1:0] lo;
   } part_prod_type;

   typedef struct packed {
      logic               sat;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } rsp_item_type;

endpackage

[rtl/cvt_sine.sv]
// Five-stage pipelined polynomial sine of a 24-bit turn fraction.
module cvt_sine (
   input  logic                               clock,
   input  logic                               en,
   input  logic [cvt_pkg::PHASE_W-1:0]        phase,
   output logic signed [cvt_pkg::SIN_W-1:0]   sine
);
   import cvt_pkg::*;

   logic [22:0]          z;
   logic [3:0]           neg_ff;
   logic [30:0]          zq1_ff, zq2_ff, zq3_ff, zq4_ff;
   logic [30:0]          z2_ff, z2b_ff, t1_ff, t_ff;
   logic [30:0]          zq1_in, z2_in, t1_in, t_in;
   logic [61:0]          sq, pt, ps;
   logic [57:0]          pc;
   logic [24:0]          mag;
   logic signed [SIN_W-1:0] mag_s, sine_in, sine_ff;

   always_comb begin
      // Odd quadrants run the quarter wave backwards.
      z      = phase[22] ? (23'h400000 - {1'b0, phase[21:0]}) : {1'b0, phase[21:0]};
      zq1_in = {z, 8'd0};
      sq     = zq1_ff * zq1_ff;
      z2_in  = sq[60:30];
      pc     = z2_ff * POLY_C;
      t1_in  = 31'(POLY_B) - {3'b000, pc[57:30]};
      pt     = z2b_ff * t1_ff;
      t_in   = POLY_A - pt[60:30];
      ps     = zq4_ff * t_ff;
      mag    = ps[60:36];
      mag_s  = $signed({1'b0, mag});
      sine_in = neg_ff[3] ? -mag_s : mag_s;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff  <= {neg_ff[2:0], phase[23]};
         zq1_ff  <= zq1_in;
         zq2_ff  <= zq1_ff;
         zq3_ff  <= zq2_ff;
         zq4_ff  <= zq3_ff;
         z2_ff   <= z2_in;
         z2b_ff  <= z2_ff;
         t1_ff   <= t1_in;
         t_ff    <= t_in;
         sine_ff <= sine_in;
      end
   end

   assign sine = sine_ff;

endmodule

[rtl/cvt_div.sv]
// Two-lane pipelined restoring divider, four quotient bits per stage.
module cvt_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic [cvt_pkg::DIV_W-1:0]     num_x,
   input  logic [cvt_pkg::DIV_W-1:0]     num_y,
   input  logic [cvt_pkg::ZOOM_W-1:0]    divisor,
   input  cvt_pkg::side_type             side_in,
   output logic [cvt_pkg::DIV_W-1:0]     quo_x,
   output logic [cvt_pkg::DIV_W-1:0]     quo_y,
   output cvt_pkg::side_type             side_out
);
   import cvt_pkg::*;

   // The dividend shifts out of the top of dq while quotient bits enter below.
   typedef struct packed {
      logic [ZOOM_W-1:0] rem;
      logic [DIV_W-1:0]  dq;
   } div_lane_type;

   function automatic div_lane_type div_digits(input div_lane_type cur,
                                               input logic [ZOOM_W-1:0] d);
      logic [ZOOM_W:0] trial;
      div_lane_type    nxt;
      nxt = cur;
      for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
         trial  = {nxt.rem, nxt.dq[DIV_W-1]};
         nxt.dq = {nxt.dq[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, d}) begin
            nxt.rem   = ZOOM_W'(trial - {1'b0, d});
            nxt.dq[0] = 1'b1;
         end else begin
            nxt.rem = trial[ZOOM_W-1:0];
         end
      end
      return nxt;
   endfunction

   div_lane_type lane_x_ff [DIV_STAGES];
   div_lane_type lane_y_ff [DIV_STAGES];
   div_lane_type src_x     [DIV_STAGES];
   div_lane_type src_y     [DIV_STAGES];
   side_type     side_ff   [DIV_STAGES];

   always_comb begin
      src_x[0] = '{rem: '0, dq: num_x};
      src_y[0] = '{rem: '0, dq: num_y};
      for (int g = 1; g < DIV_STAGES; g++) begin
         src_x[g] = lane_x_ff[g-1];
         src_y[g] = lane_y_ff[g-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int g = 0; g < DIV_STAGES; g++) begin
            lane_x_ff[g] <= div_digits(src_x[g], divisor);
            lane_y_ff[g] <= div_digits(src_y[g], divisor);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < DIV_STAGES; g++) begin
            side_ff[g].vld <= 1'b0;
         end
      end else if (en) begin
         side_ff[0] <= side_in;
         for (int g = 1; g < DIV_STAGES; g++) begin
            side_ff[g] <= side_ff[g-1];
         end
      end
   end

   assign quo_x    = lane_x_ff[DIV_STAGES-1].dq;
   assign quo_y    = lane_y_ff[DIV_STAGES-1].dq;
   assign side_out = side_ff[DIV_STAGES-1];

endmodule

[rtl/camera_view_transform_unit.sv]
// Camera view transform: world to screen and screen to world for one point per request.
// Throughput: one request per cycle; the pipeline moves as one and stops only when both
// entries of the two-entry response buffer are occupied.
// Reset: synchronous; clears the pipeline valid bits and the response buffer, and returns
// the view registers to zero, zoom to 1.0 and the angle to zero.
module camera_view_transform_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [cvt_pkg::REQ_DATA_W-1:0]      req_tdata,  // coord_x, coord_y
   input  logic [0:0]                          req_tuser,  // mode
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cvt_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // out_x, out_y
   output logic [0:0]                          rsp_tuser,  // saturated
   // Configuration writes.
   input  logic                                csr_we,
   input  logic [cvt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cvt_pkg::CSR_W-1:0]           csr_wdata
);
   import cvt_pkg::*;

   // Splits a signed operand into a high and a low half so that each multiplier
   // stays near 20 by 26 bits.
   function automatic part_prod_type mul_split(input logic signed [OPER_W-1:0] a,
                                               input logic signed [SIN_W-1:0]  k);
      logic signed [SPLIT_W:0] hi_op;
      logic signed [SPLIT_W:0] lo_op;
      part_prod_type           p;
      hi_op = {a[OPER_W-1], a[OPER_W-1:SPLIT_W]};
      lo_op = {1'b0, a[SPLIT_W-1:0]};
      p.hi  = hi_op * k;
      p.lo  = lo_op * k;
      return p;
   endfunction

   function automatic logic signed [PROD_W-1:0] join_parts(input part_prod_type p);
      return (PROD_W'($signed(p.hi)) <<< SPLIT_W) + PROD_W'($signed(p.lo));
   endfunction

   // Saturates to the coordinate range; the top bit reports clamping.
   function automatic logic [COORD_W:0] clamp_coord(input logic signed [SUM_W-1:0] v);
      logic fits;
      fits = (v[SUM_W-1:COORD_W-1] == '0) || (v[SUM_W-1:COORD_W-1] == '1);
      if (fits) begin
         return {1'b0, v[COORD_W-1:0]};
      end else if (v[SUM_W-1]) begin
         return {1'b1, 1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         return {1'b1, 1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers. Zoom is clamped to its legal range as it is
   // written, so the divider never sees zero.
   // ---------------------------------------------------------------------
   logic signed [COORD_W-1:0] view_left_ff, view_top_ff, cam_x_ff, cam_y_ff;
   logic [COORD_W-2:0]        view_width_ff, view_height_ff;
   logic [ZOOM_W-1:0]         zoom_ff, zoom_wr;
   logic [ANGLE_W-1:0]        angle_ff;

   always_comb begin
      zoom_wr = csr_wdata[ZOOM_W-1:0];
      if (zoom_wr < ZOOM_MIN) begin
         zoom_wr = ZOOM_MIN;
      end else if (zoom_wr > ZOOM_MAX) begin
         zoom_wr = ZOOM_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         view_left_ff   <= '0;
         view_top_ff    <= '0;
         view_width_ff  <= '0;
         view_height_ff <= '0;
         cam_x_ff       <= '0;
         cam_y_ff       <= '0;
         zoom_ff        <= ZOOM_RESET;
         angle_ff       <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_VIEW_LEFT:   view_left_ff   <= csr_wdata[COORD_W-1:0];
            CSR_VIEW_TOP:    view_top_ff    <= csr_wdata[COORD_W-1:0];
            CSR_VIEW_WIDTH:  view_width_ff  <= csr_wdata[COORD_W-2:0];
            CSR_VIEW_HEIGHT: view_height_ff <= csr_wdata[COORD_W-2:0];
            CSR_CAM_X:       cam_x_ff       <= csr_wdata[COORD_W-1:0];
            CSR_CAM_Y:       cam_y_ff       <= csr_wdata[COORD_W-1:0];
            CSR_ZOOM:        zoom_ff        <= zoom_wr;
            CSR_ANGLE:       angle_ff       <= csr_wdata[ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   // The viewport centre is kept doubled so that half a unit stays exact.
   logic signed [CEN_W-1:0] cx2, cy2;
   assign cx2 = {view_left_ff[COORD_W-1], view_left_ff, 1'b0} + {3'b000, view_width_ff};
   assign cy2 = {view_top_ff[COORD_W-1], view_top_ff, 1'b0} + {3'b000, view_height_ff};

   // ---------------------------------------------------------------------
   // Flow control. Every stage advances together whenever the response
   // buffer has a free entry, so a request is still taken while one
   // finished response waits at the output.
   // ---------------------------------------------------------------------
   logic [1:0] fifo_cnt_ff, fifo_cnt_in;
   logic       en;

   assign en         = (fifo_cnt_ff != 2'd2);
   assign req_tready = en;

   // ---------------------------------------------------------------------
   // Sine and cosine of the camera angle. They depend on configuration
   // alone, and the angle is stable for far longer than the five stages of
   // these units before any request reaches the rotation.
   // ---------------------------------------------------------------------
   logic [PHASE_W-1:0]      phase_s, phase_c;
   logic signed [SIN_W-1:0] sin_w, cos_w;

   assign phase_s = {angle_ff, {PHASE_SHIFT{1'b0}}};
   assign phase_c = phase_s + QUARTER_TURN;

   cvt_sine u_sin (
      .clock (clock),
      .en    (en),
      .phase (phase_s),
      .sine  (sin_w)
   );

   cvt_sine u_cos (
      .clock (clock),
      .en    (en),
      .phase (phase_c),
      .sine  (cos_w)
   );

   // ---------------------------------------------------------------------
   // Stage A: request register.
   // ---------------------------------------------------------------------
   logic                      a_vld_ff, a_mode_ff;
   logic signed [COORD_W-1:0] a_x_ff, a_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_mode_ff <= req_tuser[0];
         a_x_ff    <= req_tdata[COORD_W-1:0];
         a_y_ff    <= req_tdata[REQ_DATA_W-1:COORD_W];
      end
   end

   // ---------------------------------------------------------------------
   // Stage B: offsets from the camera for world to screen, and the divider
   // numerators for screen to world. The numerator is the magnitude of
   // (2*coord - 2*centre)*2048 plus half the zoom, which makes the
   // truncating divider round to nearest with halves away from zero.
   // ---------------------------------------------------------------------
   logic signed [DIFF_W-1:0] diff_x, diff_y;
   logic [DIFF_W-1:0]        mag_x, mag_y;
   side_type                 b_side_in, b_side_ff;
   logic [DIV_W-1:0]         b_num_x_in, b_num_y_in, b_num_x_ff, b_num_y_ff;

   always_comb begin
      diff_x = {{2{a_x_ff[COORD_W-1]}}, a_x_ff, 1'b0} - {cx2[CEN_W-1], cx2};
      diff_y = {{2{a_y_ff[COORD_W-1]}}, a_y_ff, 1'b0} - {cy2[CEN_W-1], cy2};
      mag_x  = diff_x[DIFF_W-1] ? -diff_x : diff_x;
      mag_y  = diff_y[DIFF_W-1] ? -diff_y : diff_y;
      b_num_x_in = {3'b000, mag_x[CEN_W-1:0], {CEN_SHIFT{1'b0}}}
                 + {{(DIV_W-ZOOM_W+1){1'b0}}, zoom_ff[ZOOM_W-1:1]};
      b_num_y_in = {3'b000, mag_y[CEN_W-1:0], {CEN_SHIFT{1'b0}}}
                 + {{(DIV_W-ZOOM_W+1){1'b0}}, zoom_ff[ZOOM_W-1:1]};
      b_side_in.vld   = a_vld_ff;
      b_side_in.mode  = a_mode_ff;
      b_side_in.neg_x = diff_x[DIFF_W-1];
      b_side_in.neg_y = diff_y[DIFF_W-1];
      b_side_in.dx    = {a_x_ff[COORD_W-1], a_x_ff} - {cam_x_ff[COORD_W-1], cam_x_ff};
      b_side_in.dy    = {a_y_ff[COORD_W-1], a_y_ff} - {cam_y_ff[COORD_W-1], cam_y_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_side_ff.vld <= 1'b0;
      end else if (en) begin
         b_side_ff <= b_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_num_x_ff <= b_num_x_in;
         b_num_y_ff <= b_num_y_in;
      end
   end

   // ---------------------------------------------------------------------
   // Division by zoom: twelve stages. World to screen requests pass through
   // it untouched in the side band.
   // ---------------------------------------------------------------------
   logic [DIV_W-1:0] quo_x, quo_y;
   side_type         d_side;

   cvt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .num_x    (b_num_x_ff),
      .num_y    (b_num_y_ff),
      .divisor  (zoom_ff),
      .side_in  (b_side_ff),
      .quo_x    (quo_x),
      .quo_y    (quo_y),
      .side_out (d_side)
   );

   // ---------------------------------------------------------------------
   // Rotation, three stages. World to screen turns by minus the angle,
   // screen to world by plus the angle; both share
   //    X = a*cos - b*s,  Y = a*s + b*cos  with s = -sin or +sin.
   // R1 forms split partial products, R2 joins them, R3 sums and rounds.
   // ---------------------------------------------------------------------
   logic signed [OPER_W-1:0] qx, qy, op_a, op_b;
   logic signed [SIN_W-1:0]  sin_sel;
   stage_ctl_type            r1_ctl_in, r1_ctl_ff, r2_ctl_ff, r3_ctl_ff;
   part_prod_type            r1_ac_in, r1_bs_in, r1_as_in, r1_bc_in;
   part_prod_type            r1_ac_ff, r1_bs_ff, r1_as_ff, r1_bc_ff;
   logic signed [PROD_W-1:0] r2_ac_in, r2_bs_in, r2_as_in, r2_bc_in;
   logic signed [PROD_W-1:0] r2_ac_ff, r2_bs_ff, r2_as_ff, r2_bc_ff;
   logic signed [PROD_W-1:0] rot_x, rot_y;
   logic signed [ROT_W-1:0]  r3_ux_in, r3_uy_in, r3_ux_ff, r3_uy_ff;

   always_comb begin
      qx = {1'b0, quo_x[QUO_W-1:0]};
      qy = {1'b0, quo_y[QUO_W-1:0]};
      if (d_side.neg_x) begin
         qx = -qx;
      end
      if (d_side.neg_y) begin
         qy = -qy;
      end
      if (d_side.mode == MODE_W2S) begin
         op_a    = OPER_W'(d_side.dx);
         op_b    = OPER_W'(d_side.dy);
         sin_sel = -sin_w;
      end else begin
         op_a    = qx;
         op_b    = qy;
         sin_sel = sin_w;
      end
      r1_ctl_in = '{vld: d_side.vld, mode: d_side.mode};
      r1_ac_in  = mul_split(op_a, cos_w);
      r1_bs_in  = mul_split(op_b, sin_sel);
      r1_as_in  = mul_split(op_a, sin_sel);
      r1_bc_in  = mul_split(op_b, cos_w);
      r2_ac_in  = join_parts(r1_ac_ff);
      r2_bs_in  = join_parts(r1_bs_ff);
      r2_as_in  = join_parts(r1_as_ff);
      r2_bc_in  = join_parts(r1_bc_ff);
      // Round half up to an integer (Q0) by adding half an LSB before the shift.
      rot_x     = r2_ac_ff - r2_bs_ff + (PROD_W'(1) <<< (SIN_FRAC - 1));
      rot_y     = r2_as_ff + r2_bc_ff + (PROD_W'(1) <<< (SIN_FRAC - 1));
      r3_ux_in  = rot_x[PROD_W-1:SIN_FRAC];
      r3_uy_in  = rot_y[PROD_W-1:SIN_FRAC];
   end

   // ---------------------------------------------------------------------
   // Output side, two stages. M1 scales by zoom for world to screen; M2 adds
   // the doubled centre (times 2048) plus rounding, or the camera position
   // for screen to world. The final shift and clamp sit before the buffer.
   // ---------------------------------------------------------------------
   stage_ctl_type            m1_ctl_ff, m2_ctl_ff;
   logic signed [ZOOM_W:0]   zoom_s;
   logic signed [SCALE_W+ZOOM_W:0] prod_x, prod_y;
   logic signed [SUM_W-1:0]  m1_val_x_in, m1_val_y_in, m1_val_x_ff, m1_val_y_ff;
   logic signed [SUM_W-1:0]  m2_sum_x_in, m2_sum_y_in, m2_sum_x_ff, m2_sum_y_ff;
   logic signed [SUM_W-1:0]  res_x, res_y;
   logic [COORD_W:0]         clamp_x, clamp_y;
   rsp_item_type             push_item;

   always_comb begin
      zoom_s = $signed({1'b0, zoom_ff});
      prod_x = $signed(r3_ux_ff[SCALE_W-1:0]) * zoom_s;
      prod_y = $signed(r3_uy_ff[SCALE_W-1:0]) * zoom_s;
      if (r3_ctl_ff.mode == MODE_W2S) begin
         m1_val_x_in = SUM_W'(prod_x);
         m1_val_y_in = SUM_W'(prod_y);
      end else begin
         m1_val_x_in = SUM_W'(r3_ux_ff);
         m1_val_y_in = SUM_W'(r3_uy_ff);
      end
      if (m1_ctl_ff.mode == MODE_W2S) begin
         m2_sum_x_in = (SUM_W'(cx2) <<< CEN_SHIFT) + m1_val_x_ff
                     + (SUM_W'(1) <<< (SCALE_SHIFT - 1));
         m2_sum_y_in = (SUM_W'(cy2) <<< CEN_SHIFT) + m1_val_y_ff
                     + (SUM_W'(1) <<< (SCALE_SHIFT - 1));
      end else begin
         m2_sum_x_in = m1_val_x_ff + SUM_W'(cam_x_ff);
         m2_sum_y_in = m1_val_y_ff + SUM_W'(cam_y_ff);
      end
      if (m2_ctl_ff.mode == MODE_W2S) begin
         res_x = m2_sum_x_ff >>> SCALE_SHIFT;
         res_y = m2_sum_y_ff >>> SCALE_SHIFT;
      end else begin
         res_x = m2_sum_x_ff;
         res_y = m2_sum_y_ff;
      end
      clamp_x       = clamp_coord(res_x);
      clamp_y       = clamp_coord(res_y);
      push_item.x   = clamp_x[COORD_W-1:0];
      push_item.y   = clamp_y[COORD_W-1:0];
      push_item.sat = clamp_x[COORD_W] | clamp_y[COORD_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_ctl_ff <= '0;
         r2_ctl_ff <= '0;
         r3_ctl_ff <= '0;
         m1_ctl_ff <= '0;
         m2_ctl_ff <= '0;
      end else if (en) begin
         r1_ctl_ff <= r1_ctl_in;
         r2_ctl_ff <= r1_ctl_ff;
         r3_ctl_ff <= r2_ctl_ff;
         m1_ctl_ff <= r3_ctl_ff;
         m2_ctl_ff <= m1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ac_ff    <= r1_ac_in;
         r1_bs_ff    <= r1_bs_in;
         r1_as_ff    <= r1_as_in;
         r1_bc_ff    <= r1_bc_in;
         r2_ac_ff    <= r2_ac_in;
         r2_bs_ff    <= r2_bs_in;
         r2_as_ff    <= r2_as_in;
         r2_bc_ff    <= r2_bc_in;
         r3_ux_ff    <= r3_ux_in;
         r3_uy_ff    <= r3_uy_in;
         m1_val_x_ff <= m1_val_x_in;
         m1_val_y_ff <= m1_val_y_in;
         m2_sum_x_ff <= m2_sum_x_in;
         m2_sum_y_ff <= m2_sum_y_in;
      end
   end

   // ---------------------------------------------------------------------
   // Two-entry response buffer. A result is written only when the pipeline
   // advances, which it does only while an entry is free.
   // ---------------------------------------------------------------------
   rsp_item_type fifo_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic         push, pop;

   assign push = m2_ctl_ff.vld && en;
   assign pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      fifo_cnt_in = fifo_cnt_ff;
      if (push && !pop) begin
         fifo_cnt_in = fifo_cnt_ff + 2'd1;
      end else if (pop && !push) begin
         fifo_cnt_in = fifo_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_cnt_ff <= '0;
         wr_ptr_ff   <= 1'b0;
         rd_ptr_ff   <= 1'b0;
      end else begin
         fifo_cnt_ff <= fifo_cnt_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign rsp_tvalid = (fifo_cnt_ff != 2'd0);
   assign rsp_tdata  = {fifo_ff[rd_ptr_ff].y, fifo_ff[rd_ptr_ff].x};
   assign rsp_tuser  = fifo_ff[rd_ptr_ff].sat;

endmodule

[rtl/cvt_checker.sv]
// Port-level checks for the camera view transform unit, with the bind that attaches them.
module cvt_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [cvt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic [0:0]                         rsp_tuser
);
   import cvt_pkg::*;

   localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // A waiting response holds still until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // Reset empties the response buffer.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Requests are only refused while responses are backed up.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request refused with no response pending");

   // A clamped response carries a coordinate at a range limit.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[COORD_W-1:0] == COORD_MAX || rsp_tdata[COORD_W-1:0] == COORD_MIN ||
         rsp_tdata[RSP_DATA_W-1:COORD_W] == COORD_MAX ||
         rsp_tdata[RSP_DATA_W-1:COORD_W] == COORD_MIN)
      else $error("saturated flag without a clamped coordinate");

endmodule

bind camera_view_transform_unit cvt_checker u_cvt_checker (.*);

[dv/camera_view_transform_unit_tb.sv]
// Self-checking testbench for the camera view transform unit.
`timescale 1ns / 100ps

module camera_view_transform_unit_tb;
   import cvt_pkg::*;

   // Period of 10 ns. Reset is held only at the start of the run and is never asserted again.
   localparam int RESET_CYCLES = 4;
   // Extra margin that drain() waits after the last expected response has arrived.
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASES       = 8;
   localparam int PHASE_POINTS = 210;
   localparam int LONG_HOLD    = 300;

   localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] C_MIN = 32'h8000_0000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // coord_x [31:0], coord_y [63:32]
   logic [0:0]            req_tuser;   // mode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // out_x [31:0], out_y [63:32]
   logic [0:0]            rsp_tuser;   // saturated
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_W-1:0]      csr_wdata;

   camera_view_transform_unit DUT (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // The testbench's own copy of the view registers.
   longint          m_left, m_top, m_width, m_height, m_cam_x, m_cam_y;
   longint unsigned m_zoom;
   logic [ANGLE_W-1:0] m_angle;

   // Points still in flight, oldest first.
   rsp_item_type pending_points[$];
   int  error_count = 0;
   bit  idle_enable = 1'b1;
   int  hold_request = 0;
   int  cycle_count = 0;

   // Applies a register write to the local copy, as the block applies it.
   function automatic void apply_csr(csr_index_type idx, logic [31:0] val);
      case (idx)
         CSR_VIEW_LEFT:   m_left   = longint'($signed(val));
         CSR_VIEW_TOP:    m_top    = longint'($signed(val));
         CSR_VIEW_WIDTH:  m_width  = longint'(val[30:0]);
         CSR_VIEW_HEIGHT: m_height = longint'(val[30:0]);
         CSR_CAM_X:       m_cam_x  = longint'($signed(val));
         CSR_CAM_Y:       m_cam_y  = longint'($signed(val));
         CSR_ZOOM: begin
            m_zoom = val[15:0];
            if (m_zoom < ZOOM_MIN) m_zoom = ZOOM_MIN;
            if (m_zoom > ZOOM_MAX) m_zoom = ZOOM_MAX;
         end
         CSR_ANGLE:       m_angle  = val[ANGLE_W-1:0];
         default: ;
      endcase
   endfunction

   // Sine of a 24-bit turn fraction in Q24, odd polynomial over a quarter turn.
   function automatic longint sine_q24(logic [23:0] ph);
      logic [1:0] quad;
      logic [63:0] f, z, zq, z2, t, s;
      quad = ph[23:22];
      f    = 64'(ph[21:0]);
      z    = quad[0] ? (64'h40_0000 - f) : f;
      zq   = z << 8;
      z2   = (zq * zq) >> 30;
      t    = 64'(POLY_B) - ((z2 * 64'(POLY_C)) >> 30);
      t    = 64'(POLY_A) - ((z2 * t) >> 30);
      s    = ((zq * t) >> 30) >> (30 - SIN_FRAC);
      return quad[1] ? -longint'(s) : longint'(s);
   endfunction

   function automatic longint round_q(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   // Divide by a positive divisor, rounding halves away from zero.
   function automatic longint div_nearest(longint n, longint d);
      longint m, q;
      m = (n < 0) ? -n : n;
      q = (m + d / 2) / d;
      return (n < 0) ? -q : q;
   endfunction

   // Adds half the doubled centre to r scaled by zoom, rounding half up.
   function automatic longint zoom_and_centre(longint r, longint cen2);
      longint z, hi, lo;
      z  = longint'(m_zoom);
      hi = r >>> 16;
      lo = r - hi * 65536;
      return hi * z * 16 + ((cen2 * 2048 + lo * z + 2048) >>> 12);
   endfunction

   function automatic logic [31:0] clamp_coord(longint v, inout logic sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return C_MAX;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return C_MIN;
      end
      return v[31:0];
   endfunction

   // Expected response for one point under the current view registers.
   function automatic rsp_item_type transform_point(logic mode, logic [31:0] px, logic [31:0] py);
      logic [23:0] ph;
      longint sn, cs, x, y, cx2, cy2, ux, uy, qx, qy, rx, ry;
      rsp_item_type r;
      logic sat;
      ph  = 24'(m_angle) << PHASE_SHIFT;
      sn  = sine_q24(ph);
      cs  = sine_q24(ph + QUARTER_TURN);
      x   = longint'($signed(px));
      y   = longint'($signed(py));
      cx2 = 2 * m_left + m_width;
      cy2 = 2 * m_top + m_height;
      sat = 1'b0;
      if (mode == MODE_W2S) begin
         ux = round_q((x - m_cam_x) * cs + (y - m_cam_y) * sn, SIN_FRAC);
         uy = round_q((y - m_cam_y) * cs - (x - m_cam_x) * sn, SIN_FRAC);
         rx = zoom_and_centre(ux, cx2);
         ry = zoom_and_centre(uy, cy2);
      end else begin
         qx = div_nearest((2 * x - cx2) * 2048, longint'(m_zoom));
         qy = div_nearest((2 * y - cy2) * 2048, longint'(m_zoom));
         rx = round_q(qx * cs - qy * sn, SIN_FRAC) + m_cam_x;
         ry = round_q(qx * sn + qy * cs, SIN_FRAC) + m_cam_y;
      end
      r.x   = clamp_coord(rx, sat);
      r.y   = clamp_coord(ry, sat);
      r.sat = clamp_coord(0, sat) == 32'd0 ? sat : sat;
      return r;
   endfunction

   // Holds one register write for a single edge; csr_end lowers the enable after a batch.
   task automatic csr_write(csr_index_type idx, logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      apply_csr(idx, val);
   endtask

   task automatic csr_end();
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Offers one request and records its expected response once it is taken.
   task automatic send_point(logic mode, logic [31:0] px, logic [31:0] py,
                             bit typed, rsp_item_type typed_rsp);
      req_tvalid <= 1'b1;
      req_tdata  <= {py, px};
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      pending_points.insert(pending_points.size(),
                            typed ? typed_rsp : transform_point(mode, px, py));
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Lowers valid and waits until every expected response has arrived.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
         2: return $urandom_range(0, 1) ? C_MAX - $urandom_range(0, 255)
                                        : C_MIN + $urandom_range(0, 255);
         default: return 32'($signed($urandom_range(0, 268435456)) - 134217728);
      endcase
   endfunction

   // Directed requests. After reset the transform is the identity in both directions;
   // with the camera pushed to opposite extremes the offsets overflow and clamp.
   typedef struct {
      logic         mode;
      logic [31:0]  x;
      logic [31:0]  y;
      bit           typed;
      rsp_item_type rsp;
   } point_row_type;

   point_row_type identity_rows[12] = '{
      '{MODE_W2S, 32'd0,         32'd0,         1'b1, '{1'b0, 32'd0,         32'd0}},
      '{MODE_S2W, 32'd0,         32'd0,         1'b1, '{1'b0, 32'd0,         32'd0}},
      '{MODE_W2S, C_MAX,         C_MIN,         1'b1, '{1'b0, C_MIN,         C_MAX}},
      '{MODE_S2W, C_MAX,         C_MIN,         1'b1, '{1'b0, C_MIN,         C_MAX}},
      '{MODE_W2S, C_MIN,         C_MAX,         1'b1, '{1'b0, C_MAX,         C_MIN}},
      '{MODE_S2W, C_MIN,         C_MAX,         1'b1, '{1'b0, C_MAX,         C_MIN}},
      '{MODE_W2S, 32'hFFFF_FFFF, 32'h0001_0000, 1'b1, '{1'b0, 32'h0001_0000, 32'hFFFF_FFFF}},
      '{MODE_S2W, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, '{1'b0, 32'hAAAA_AAAA, 32'h5555_5555}},
      '{MODE_W2S, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, '{1'b0, 32'h5555_5555, 32'hAAAA_AAAA}},
      '{MODE_S2W, 32'h0000_8000, 32'hFFFF_8000, 1'b0, '{1'b0, 32'd0, 32'd0}},
      '{MODE_W2S, 32'h1234_5678, 32'h8765_4321, 1'b0, '{1'b0, 32'd0, 32'd0}},
      '{MODE_S2W, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, '{1'b0, 32'd0, 32'd0}}
   };

   // Run with camera x at its minimum and camera y at its maximum.
   point_row_type clamp_rows[6] = '{
      '{MODE_W2S, C_MAX,  C_MIN, 1'b1, '{1'b1, C_MIN,         C_MAX}},
      '{MODE_W2S, 32'd0,  32'd0, 1'b1, '{1'b1, 32'h8000_0001, C_MAX}},
      '{MODE_S2W, C_MAX,  C_MAX, 1'b1, '{1'b1, C_MAX,         32'hFFFF_FFFF}},
      '{MODE_S2W, C_MIN,  C_MIN, 1'b1, '{1'b1, 32'hFFFF_FFFF, C_MIN}},
      '{MODE_W2S, C_MIN,  C_MAX, 1'b0, '{1'b0, 32'd0, 32'd0}},
      '{MODE_S2W, 32'd1,  32'd1, 1'b0, '{1'b0, 32'd0, 32'd0}}
   };

   // Response monitor: every accepted response is compared with the oldest expectation.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_points.size() == 0) begin
            $error("response with no request outstanding: out_x=%h out_y=%h",
                   rsp_tdata[31:0], rsp_tdata[63:32]);
            error_count++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_tdata[31:0] !== want.x) begin
               $error("out_x: expected %h, got %h", want.x, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[63:32] !== want.y) begin
               $error("out_y: expected %h, got %h", want.y, rsp_tdata[63:32]);
               error_count++;
            end
            if (rsp_tuser[0] !== want.sat) begin
               $error("saturated: expected %b, got %b", want.sat, rsp_tuser[0]);
               error_count++;
            end
         end
      end
   end

   // Response side: random stalls, one long hold on request, and none once idling is off.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         if (hold_request > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      logic [31:0] zoom_val, angle_val, width_val;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_VIEW_LEFT;
      csr_wdata  = '0;
      apply_csr(CSR_VIEW_LEFT, 0);
      apply_csr(CSR_VIEW_TOP, 0);
      apply_csr(CSR_VIEW_WIDTH, 0);
      apply_csr(CSR_VIEW_HEIGHT, 0);
      apply_csr(CSR_CAM_X, 0);
      apply_csr(CSR_CAM_Y, 0);
      apply_csr(CSR_ZOOM, 32'(ZOOM_RESET));
      apply_csr(CSR_ANGLE, 0);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: identity in both directions.
      foreach (identity_rows[i])
         send_point(identity_rows[i].mode, identity_rows[i].x, identity_rows[i].y,
                    identity_rows[i].typed, identity_rows[i].rsp);
      drain();

      // Camera at opposite extremes so that the offsets overflow.
      csr_write(CSR_CAM_X, C_MIN);
      csr_write(CSR_CAM_Y, C_MAX);
      csr_end();
      foreach (clamp_rows[i])
         send_point(clamp_rows[i].mode, clamp_rows[i].x, clamp_rows[i].y,
                    clamp_rows[i].typed, clamp_rows[i].rsp);
      drain();

      // Random phases, each under its own view settings. The first ones take the
      // extremes of zoom (including out-of-range writes that clamp), angle and size.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin zoom_val = 32'd0;       angle_val = 32'h0000_8000; width_val = 32'hFFFF_FFFF; end
            1: begin zoom_val = 32'h0000_FFFF; angle_val = 32'h0000_7FFF; width_val = 32'd0; end
            2: begin zoom_val = 32'd410;     angle_val = 32'h0000_4000; width_val = 32'h7FFF_FFFF; end
            3: begin zoom_val = 32'd40960;   angle_val = 32'hFFFF_C000; width_val = $urandom; end
            default: begin
               zoom_val  = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(300, 42000);
               angle_val = $urandom;
               width_val = $urandom;
            end
         endcase
         csr_write(CSR_VIEW_LEFT,   p == 1 ? C_MIN : (p == 2 ? C_MAX : random_coord()));
         csr_write(CSR_VIEW_TOP,    p == 1 ? C_MAX : (p == 2 ? C_MIN : random_coord()));
         csr_write(CSR_VIEW_WIDTH,  width_val);
         csr_write(CSR_VIEW_HEIGHT, p < 3 ? ~width_val : $urandom);
         csr_write(CSR_CAM_X,       p == 0 ? C_MAX : random_coord());
         csr_write(CSR_CAM_Y,       p == 0 ? C_MIN : random_coord());
         csr_write(CSR_ZOOM,        zoom_val);
         csr_write(CSR_ANGLE,       angle_val);
         csr_end();

         // In the third phase, the receiver holds off long enough to fill the pipeline.
         if (p == 2) hold_request = LONG_HOLD;
         // The last phase runs with no idling on either side.
         if (p == PHASES - 1) idle_enable = 1'b0;

         for (int n = 0; n < PHASE_POINTS; n++)
            send_point($urandom_range(0, 1), random_coord(), random_coord(), 1'b0, '0);
         drain();
      end

      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/cvt_pkg.sv
rtl/cvt_sine.sv
rtl/cvt_div.sv
rtl/camera_view_transform_unit.sv
rtl/cvt_checker.sv
dv/camera_view_transform_unit_tb.sv
